// ===== rtl/core/dcp_pkg.sv =====
`default_nettype none

package dcp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_TYPE,
    PH_COLOR,
    PH_COLOR_T,
    PH_DUR,
    PH_DUR_T,
    PH_SIZE,
    PH_SIZE_T,
    PH_QUOTE,
    PH_TEXT,
    PH_AFTER
  } phase_t;

  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;

  localparam logic [23:0] TYPE_BLK = 24'h424C4B;
  localparam logic [23:0] TYPE_MSG = 24'h4D5347;
  localparam logic [23:0] TYPE_DEF = 24'h444546;

  localparam logic [1:0] KIND_BLK = 2'd0;
  localparam logic [1:0] KIND_MSG = 2'd1;
  localparam logic [1:0] KIND_DEF = 2'd2;

  localparam logic [31:0] MSG_DUR_RESET = 32'd35000;

  typedef struct packed {
    logic        status;
    logic [1:0]  kind;
    logic [2:0]  color;
    logic [2:0]  size;
    logic [31:0] dur;
    logic [5:0]  len;
  } result_t;

  // decimal accumulate with saturation at all ones
  function automatic logic [31:0] acc_digit(input logic [31:0] a, input logic [3:0] d);
    logic [35:0] v;
    v = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {32'd0, d};
    acc_digit = (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // value mod 5 depends only on the last digit (10 is a multiple of 5)
  function automatic logic [2:0] digit_mod5(input logic [3:0] d);
    case (d)
      4'd0, 4'd5: digit_mod5 = 3'd0;
      4'd1, 4'd6: digit_mod5 = 3'd1;
      4'd2, 4'd7: digit_mod5 = 3'd2;
      4'd3, 4'd8: digit_mod5 = 3'd3;
      4'd4, 4'd9: digit_mod5 = 3'd4;
      default:    digit_mod5 = 3'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/display_command_parser.sv =====
// display_command_parser
// Byte-serial parser for display command frames ($TYPE,color,... ending in '*').
// Input: one character per beat on s_axis; tready is high unless a finished
// frame is already queued behind the run currently being sent.
// Output: on each '*' the block sends a run of result beats on m_axis, one
// per stored text character, or a single beat for a frame without text or a
// rejected frame; tlast marks the final beat of the run.
// Throughput: one input byte per cycle while s_axis_tready is high; one result
// beat per cycle within a run while m_axis is not stalled, with a gap between runs.
// A frame result passes the queue entry, sender, read stage and output register.
// Text is held in a two-bank synchronous RAM: the parser fills one bank while
// the sender reads the other, so bytes of the next frame keep flowing while a
// run drains. A second '*' stalls input until the current run is fully read.
// A receiver stall on m_axis holds the output register and the read stage;
// the input side is not held by it until a second finished frame waits.
// cfg_we writes message_duration_ms from cfg_wdata; it is used for MSG frames.
// Reset: parser idle, no frame open, queue and output empty, message
// duration back to 35000 ms. RAM contents are not cleared.
`default_nettype none

module display_command_parser
  import dcp_pkg::*;
#(
  parameter int TEXT_MAX  = 64,
  parameter int FRAME_MAX = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // [2:0] color, [5:3] font_size,
                                           // [37:6] duration_ms, [43:38] text_length,
                                           // [51:44] text_char, [55:52] zero
  output logic [3:0]       m_axis_tuser,   // [0] status, [2:1] command_kind,
                                           // [3] char_valid
  output logic             m_axis_tlast
);

  localparam int TEXT_CAP  = ((TEXT_MAX - 1) > 63) ? 63 : (TEXT_MAX - 1);
  localparam int IDX_W     = $clog2(TEXT_CAP);
  localparam int CNT_W     = $clog2(TEXT_CAP + 1);
  localparam int MEM_DEPTH = 2 ** (IDX_W + 1);
  localparam int FC_W      = $clog2(FRAME_MAX + 1);
  localparam logic [FC_W-1:0]  FRAME_LIM = FC_W'(FRAME_MAX);
  localparam logic [CNT_W-1:0] CAP_LIM   = CNT_W'(TEXT_CAP);

  logic [31:0] msg_dur;

  // parser state
  phase_t          phase, phase_next;
  logic [23:0]     type_chars, type_chars_next;
  logic [2:0]      type_count, type_count_next;
  logic [1:0]      kind, kind_next;
  logic [31:0]     acc, acc_next;
  logic [2:0]      acc_mod5, acc_mod5_next;
  logic [2:0]      color, color_next;
  logic [2:0]      size, size_next;
  logic [CNT_W-1:0] tcount, tcount_next;
  logic [7:0]      last_char, last_char_next;
  logic [FC_W-1:0] fcount, fcount_next;
  logic            error, error_next;
  logic            wbank;

  // finished frame queue entry
  logic             desc_full;
  result_t          desc, desc_new;
  logic [CNT_W-1:0] desc_num, desc_num_new;
  logic             desc_text, desc_text_new;
  logic             push;

  // sender
  logic             em_busy;
  result_t          em;
  logic [CNT_W-1:0] em_num, em_idx;
  logic             em_text;
  logic             ebank, em_bank;

  logic             s1_valid, s1_cv, s1_last;
  result_t          s1;
  logic [7:0]       rdata;

  result_t          out_r;
  logic [7:0]       out_char;
  logic             out_cv, out_last;

  logic [7:0] text_mem [0:MEM_DEPTH-1];
  logic             mem_we;
  logic [IDX_W:0]   mem_wa;
  logic [7:0]       mem_wd;

  logic       in_fire, adv, load;
  logic [7:0] b;
  logic       num_field, is_digit, is_sign, in_tail, ok;
  phase_t     tail_phase;
  logic [FC_W-1:0] frame_inc;
  logic [CNT_W-1:0] tcount_m1;

  assign s_axis_tready = !(desc_full && em_busy);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign b = s_axis_tdata;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_sign = (b == CH_PLUS) || (b == CH_MINUS);
  assign tcount_m1 = tcount - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_dur <= MSG_DUR_RESET;
    end else if (cfg_we) begin
      msg_dur <= cfg_wdata;
    end
  end

  always_comb begin
    phase_next      = phase;
    type_chars_next = type_chars;
    type_count_next = type_count;
    kind_next       = kind;
    acc_next        = acc;
    acc_mod5_next   = acc_mod5;
    color_next      = color;
    size_next       = size;
    tcount_next     = tcount;
    last_char_next  = last_char;
    fcount_next     = fcount;
    error_next      = error;
    mem_we          = 1'b0;
    mem_wa          = {wbank, tcount[IDX_W-1:0]};
    mem_wd          = b;
    push            = 1'b0;
    desc_new        = '0;
    desc_num_new    = CNT_W'(1);
    desc_text_new   = 1'b0;
    num_field       = 1'b0;
    ok              = 1'b0;
    frame_inc = (phase != PH_IDLE && fcount < FRAME_LIM) ? fcount + FC_W'(1) : fcount;

    case (phase)
      PH_COLOR, PH_COLOR_T: tail_phase = PH_COLOR_T;
      PH_DUR, PH_DUR_T:     tail_phase = PH_DUR_T;
      default:              tail_phase = PH_SIZE_T;
    endcase
    in_tail = (phase == tail_phase);

    if (in_fire) begin
      if (b == CH_DOLLAR) begin
        type_chars_next = '0;
        type_count_next = '0;
        kind_next       = KIND_BLK;
        acc_next        = '0;
        acc_mod5_next   = '0;
        color_next      = '0;
        size_next       = '0;
        tcount_next     = '0;
        error_next      = 1'b0;
        fcount_next     = FC_W'(1);
        phase_next      = PH_TYPE;
      end else if (b == CH_STAR) begin
        push = 1'b1;
        if (phase != PH_IDLE && !error && frame_inc < FRAME_LIM) begin
          if (kind == KIND_BLK) begin
            ok = (phase == PH_DUR) || (phase == PH_DUR_T);
          end else begin
            ok = (phase == PH_AFTER);
          end
        end
        if (!ok) begin
          desc_new.status = 1'b1;
        end else begin
          desc_new.kind  = kind;
          desc_new.color = color;
          desc_new.size  = (kind == KIND_BLK) ? 3'd0 : size;
          case (kind)
            KIND_BLK: desc_new.dur = acc;
            KIND_MSG: desc_new.dur = msg_dur;
            default:  desc_new.dur = '0;
          endcase
          if (kind != KIND_BLK && tcount != '0) begin
            desc_new.len  = 6'(tcount);
            desc_num_new  = tcount;
            desc_text_new = 1'b1;
          end
        end
        type_chars_next = '0;
        type_count_next = '0;
        kind_next       = KIND_BLK;
        acc_next        = '0;
        acc_mod5_next   = '0;
        color_next      = '0;
        size_next       = '0;
        tcount_next     = '0;
        error_next      = 1'b0;
        fcount_next     = '0;
        phase_next      = PH_IDLE;
      end else begin
        fcount_next = frame_inc;
        case (phase)
          PH_TYPE: begin
            if (b == CH_COMMA) begin
              acc_next      = '0;
              acc_mod5_next = '0;
              phase_next    = PH_COLOR;
              if (type_count == 3'd3 && type_chars == TYPE_BLK) begin
                kind_next = KIND_BLK;
              end else if (type_count == 3'd3 && type_chars == TYPE_MSG) begin
                kind_next = KIND_MSG;
              end else if (type_count == 3'd3 && type_chars == TYPE_DEF) begin
                kind_next = KIND_DEF;
              end else begin
                error_next = 1'b1;
                phase_next = PH_AFTER;
              end
            end else if (type_count < 3'd3) begin
              type_chars_next = {type_chars[15:0], b};
              type_count_next = type_count + 3'd1;
            end else begin
              type_count_next = 3'd4;
            end
          end
          PH_COLOR, PH_COLOR_T: begin
            if (b == CH_COMMA) begin
              color_next    = acc[2:0];
              acc_next      = '0;
              acc_mod5_next = '0;
              phase_next    = (kind == KIND_BLK) ? PH_DUR : PH_SIZE;
            end else begin
              num_field = 1'b1;
            end
          end
          PH_DUR, PH_DUR_T: begin
            num_field = 1'b1;
          end
          PH_SIZE, PH_SIZE_T: begin
            if (b == CH_COMMA) begin
              size_next     = acc_mod5;
              acc_next      = '0;
              acc_mod5_next = '0;
              phase_next    = PH_QUOTE;
            end else begin
              num_field = 1'b1;
            end
          end
          PH_QUOTE: begin
            if (b == CH_QUOTE) begin
              tcount_next = '0;
              phase_next  = PH_TEXT;
            end else begin
              error_next = 1'b1;
              phase_next = PH_AFTER;
            end
          end
          PH_TEXT: begin
            if (b == CH_QUOTE && tcount != '0 && last_char == CH_BACKSLASH) begin
              mem_we         = 1'b1;
              mem_wa         = {wbank, tcount_m1[IDX_W-1:0]};
              mem_wd         = CH_QUOTE;
              last_char_next = CH_QUOTE;
            end else if (b == CH_QUOTE) begin
              phase_next = PH_AFTER;
            end else if (tcount < CAP_LIM) begin
              mem_we         = 1'b1;
              last_char_next = b;
              tcount_next    = tcount + CNT_W'(1);
            end else begin
              error_next = 1'b1;
              phase_next = PH_AFTER;
            end
          end
          default: begin
          end
        endcase

        if (num_field) begin
          if (is_sign) begin
            error_next = 1'b1;
            phase_next = PH_AFTER;
          end else if (!in_tail && is_digit) begin
            acc_next      = acc_digit(acc, b[3:0]);
            acc_mod5_next = (acc_digit(acc, b[3:0]) == 32'hFFFF_FFFF) ? 3'd0
                                                                        : digit_mod5(b[3:0]);
          end else begin
            phase_next = tail_phase;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      type_chars <= '0;
      type_count <= '0;
      kind       <= KIND_BLK;
      acc        <= '0;
      acc_mod5   <= '0;
      color      <= '0;
      size       <= '0;
      tcount     <= '0;
      fcount     <= '0;
      error      <= 1'b0;
      wbank      <= 1'b0;
    end else begin
      phase      <= phase_next;
      type_chars <= type_chars_next;
      type_count <= type_count_next;
      kind       <= kind_next;
      acc        <= acc_next;
      acc_mod5   <= acc_mod5_next;
      color      <= color_next;
      size       <= size_next;
      tcount     <= tcount_next;
      fcount     <= fcount_next;
      error      <= error_next;
      if (push) begin
        wbank <= !wbank;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_char <= last_char_next;
    if (push) begin
      desc      <= desc_new;
      desc_num  <= desc_num_new;
      desc_text <= desc_text_new;
    end
  end

  // text RAM: parser writes one bank, sender reads the other
  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata <= text_mem[{em_bank, em_idx[IDX_W-1:0]}];
    end
  end

  assign adv  = !m_axis_tvalid || m_axis_tready;
  assign load = desc_full && !em_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_full <= 1'b0;
      em_busy   <= 1'b0;
      ebank     <= 1'b0;
      s1_valid  <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (push) begin
        desc_full <= 1'b1;
      end else if (load) begin
        desc_full <= 1'b0;
      end
      if (load) begin
        em_busy <= 1'b1;
        ebank   <= !ebank;
      end else if (em_busy && adv && (em_idx + CNT_W'(1) == em_num)) begin
        em_busy <= 1'b0;
      end
      if (adv) begin
        s1_valid      <= em_busy;
        m_axis_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      em      <= desc;
      em_num  <= desc_num;
      em_text <= desc_text;
      em_bank <= ebank;
      em_idx  <= '0;
    end else if (em_busy && adv) begin
      em_idx <= em_idx + CNT_W'(1);
    end
    if (adv) begin
      s1       <= em;
      s1_cv    <= em_text;
      s1_last  <= (em_idx + CNT_W'(1) == em_num);
      out_r    <= s1;
      out_cv   <= s1_cv;
      out_last <= s1_last;
      out_char <= s1_cv ? rdata : 8'd0;
    end
  end

  assign m_axis_tdata = {4'd0, out_char, out_r.len, out_r.dur, out_r.size, out_r.color};
  assign m_axis_tuser = {out_cv, out_r.kind, out_r.status};
  assign m_axis_tlast = out_last;

endmodule

`default_nettype wire

// ===== bench/dcp_result_checker.sv =====
`default_nettype none

module dcp_result_checker
  import dcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [55:0] m_axis_tdata,
  input  wire logic [3:0]  m_axis_tuser,
  input  wire logic        m_axis_tlast,
  output int               mismatch_count,
  output int               results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_CAP    = 63;
  localparam int FRAME_LIMIT = 128;

  typedef struct packed {
    logic        status;
    logic [1:0]  kind;
    logic [2:0]  color;
    logic [2:0]  font_size;
    logic [31:0] dur;
    logic [5:0]  len;
    logic [7:0]  ch;
    logic        valid;
    logic        last;
  } cmd_beat_t;

  cmd_beat_t   awaited_beats[$];

  logic [31:0] msg_duration;
  phase_t      phase;
  logic [23:0] type_chars;
  int          type_cnt;
  logic [1:0]  kind;
  logic [31:0] accum;
  logic [2:0]  color;
  logic [2:0]  font_size;
  logic [7:0]  text_buf [TEXT_CAP];
  int          text_cnt;
  int          frame_cnt;
  bit          frame_bad;

  function automatic void clear_frame();
    type_chars = '0;
    type_cnt   = 0;
    kind       = KIND_BLK;
    accum      = '0;
    color      = '0;
    font_size  = '0;
    text_cnt   = 0;
    frame_cnt  = 0;
    frame_bad  = 1'b0;
  endfunction

  function automatic void reject_frame();
    frame_bad = 1'b1;
    phase     = PH_AFTER;
  endfunction

  function automatic void number_byte(input logic [7:0] b, input phase_t tail);
    logic [35:0] wide;
    if (b == CH_PLUS || b == CH_MINUS) begin
      reject_frame();
    end else if (phase != tail && b >= CH_ZERO && b <= CH_NINE) begin
      wide  = 36'(accum) * 36'd10 + 36'(b) - 36'(CH_ZERO);
      accum = (wide > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
    end else begin
      phase = tail;
    end
  endfunction

  function automatic void close_frame();
    bit          ok;
    logic [31:0] d;
    cmd_beat_t   r;
    ok = 1'b0;
    d  = '0;
    if (phase != PH_IDLE && !frame_bad && frame_cnt <= FRAME_LIMIT - 1) begin
      if (kind == KIND_BLK && (phase == PH_DUR || phase == PH_DUR_T)) begin
        ok = 1'b1;
        d  = accum;
      end else if (kind != KIND_BLK && phase == PH_AFTER) begin
        ok = 1'b1;
        d  = (kind == KIND_MSG) ? msg_duration : 32'd0;
      end
    end
    r      = '0;
    r.last = 1'b1;
    if (!ok) begin
      r.status = 1'b1;
      awaited_beats.push_back(r);
    end else begin
      r.kind      = kind;
      r.color     = color;
      r.font_size = (kind == KIND_BLK) ? 3'd0 : font_size;
      r.dur       = d;
      if (kind == KIND_BLK || text_cnt == 0) begin
        awaited_beats.push_back(r);
      end else begin
        for (int i = 0; i < text_cnt; i++) begin
          r.len   = 6'(text_cnt);
          r.ch    = text_buf[i];
          r.valid = 1'b1;
          r.last  = (i == text_cnt - 1);
          awaited_beats.push_back(r);
        end
      end
    end
    clear_frame();
    phase = PH_IDLE;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    if (b == CH_DOLLAR) begin
      clear_frame();
      frame_cnt = 1;
      phase     = PH_TYPE;
      return;
    end
    if (phase != PH_IDLE && frame_cnt < FRAME_LIMIT) frame_cnt++;
    if (b == CH_STAR) begin
      close_frame();
      return;
    end
    case (phase)
      PH_TYPE: begin
        if (b == CH_COMMA) begin
          if (type_cnt == 3 && type_chars == TYPE_BLK) begin
            kind  = KIND_BLK;
            phase = PH_COLOR;
          end else if (type_cnt == 3 && type_chars == TYPE_MSG) begin
            kind  = KIND_MSG;
            phase = PH_COLOR;
          end else if (type_cnt == 3 && type_chars == TYPE_DEF) begin
            kind  = KIND_DEF;
            phase = PH_COLOR;
          end else begin
            reject_frame();
          end
          accum = '0;
        end else if (type_cnt < 3) begin
          type_chars = {type_chars[15:0], b};
          type_cnt++;
        end else begin
          type_cnt = 4;
        end
      end
      PH_COLOR, PH_COLOR_T: begin
        if (b == CH_COMMA) begin
          color = 3'(accum % 8);
          accum = '0;
          phase = (kind == KIND_BLK) ? PH_DUR : PH_SIZE;
        end else begin
          number_byte(b, PH_COLOR_T);
        end
      end
      PH_DUR, PH_DUR_T: number_byte(b, PH_DUR_T);
      PH_SIZE, PH_SIZE_T: begin
        if (b == CH_COMMA) begin
          font_size = 3'(accum % 5);
          accum     = '0;
          phase     = PH_QUOTE;
        end else begin
          number_byte(b, PH_SIZE_T);
        end
      end
      PH_QUOTE: begin
        if (b == CH_QUOTE) begin
          text_cnt = 0;
          phase    = PH_TEXT;
        end else begin
          reject_frame();
        end
      end
      PH_TEXT: begin
        if (b == CH_QUOTE && text_cnt > 0 && text_cnt <= TEXT_CAP &&
            text_buf[text_cnt-1] == CH_BACKSLASH) begin
          text_buf[text_cnt-1] = CH_QUOTE;
        end else if (b == CH_QUOTE) begin
          phase = PH_AFTER;
        end else if (text_cnt < TEXT_CAP) begin
          text_buf[text_cnt] = b;
          text_cnt++;
        end else begin
          reject_frame();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    cmd_beat_t got;
    cmd_beat_t want;
    if (rst) begin
      msg_duration = MSG_DUR_RESET;
      clear_frame();
      phase = PH_IDLE;
      awaited_beats.delete();
    end else begin
      if (cfg_we) msg_duration = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        got.status    = m_axis_tuser[0];
        got.kind      = m_axis_tuser[2:1];
        got.valid     = m_axis_tuser[3];
        got.color     = m_axis_tdata[2:0];
        got.font_size = m_axis_tdata[5:3];
        got.dur       = m_axis_tdata[37:6];
        got.len       = m_axis_tdata[43:38];
        got.ch        = m_axis_tdata[51:44];
        got.last      = m_axis_tlast;
        if (awaited_beats.size() == 0) begin
          $error("unexpected result beat: status %0d, text_char %0d", got.status, got.ch);
          mismatch_count++;
        end else begin
          want = awaited_beats.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("command_kind", 32'(want.kind), 32'(got.kind));
          check_field("color", 32'(want.color), 32'(got.color));
          check_field("font_size", 32'(want.font_size), 32'(got.font_size));
          check_field("duration_ms", want.dur, got.dur);
          check_field("text_length", 32'(want.len), 32'(got.len));
          check_field("text_char", 32'(want.ch), 32'(got.ch));
          check_field("char_valid", 32'(want.valid), 32'(got.valid));
          check_field("last", 32'(want.last), 32'(got.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) parse_rx_byte(s_axis_tdata);
    end
    results_owed <= awaited_beats.size();
  end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
  import dcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [55:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int          mismatch_count;
  int          results_owed;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          cycles = 0;
  int          bytes_sent = 0;
  logic [7:0]  frame_bytes[$];

  display_command_parser dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  dcp_result_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** display_command_parser: FAILED **");
      $finish;
    end
  end

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  // any byte that neither opens nor closes a frame nor a text
  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_DOLLAR || c == CH_STAR || c == CH_QUOTE);
    return c;
  endfunction

  function automatic void push_digits(input int max_digits);
    int n;
    n = $urandom_range(max_digits);
    repeat (n) frame_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
    if ($urandom_range(7) == 0) begin
      push_text("x");
      frame_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
  endfunction

  function automatic void build_good_frame();
    int k;
    int n;
    k = $urandom_range(2);
    push_text(k == 0 ? "$BLK," : (k == 1 ? "$MSG," : "$DEF,"));
    push_digits($urandom_range(9) == 0 ? 12 : 3);
    frame_bytes.push_back(CH_COMMA);
    if (k == 0) begin
      push_digits($urandom_range(4) == 0 ? 12 : 6);
    end else begin
      push_digits($urandom_range(9) == 0 ? 12 : 2);
      frame_bytes.push_back(CH_COMMA);
      frame_bytes.push_back(CH_QUOTE);
      n = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(8);
      repeat (n) begin
        if ($urandom_range(7) == 0) begin
          frame_bytes.push_back(CH_BACKSLASH);
          frame_bytes.push_back(CH_QUOTE);
        end else begin
          frame_bytes.push_back(text_byte());
        end
      end
      frame_bytes.push_back(CH_QUOTE);
      n = ($urandom_range(15) == 0) ? $urandom_range(64)
                                    : (($urandom_range(3) == 0) ? $urandom_range(3) : 0);
      repeat (n) frame_bytes.push_back(text_byte());
    end
    frame_bytes.push_back(CH_STAR);
  endfunction

  function automatic void build_broken_frame();
    int pos;
    int n;
    build_good_frame();
    case ($urandom_range(3))
      0: begin
        n = $urandom_range(frame_bytes.size() - 2, 1);
        while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
        frame_bytes.push_back(CH_STAR);
      end
      1: begin
        pos = $urandom_range(frame_bytes.size() - 2, 1);
        frame_bytes[pos] = 8'($urandom_range(255));
      end
      2: begin
        pos = $urandom_range(frame_bytes.size() - 2, 5);
        frame_bytes.insert(pos, $urandom_range(1) ? CH_PLUS : CH_MINUS);
      end
      default: begin
        frame_bytes.delete();
        n = $urandom_range(10, 1);
        repeat (n) frame_bytes.push_back(8'($urandom_range(255)));
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frames();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    frame_bytes.delete();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_duration(input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic directed_frames();
    push_text("*");
    push_text("q$BLK,3,1500*");
    push_text("$MSG,12,7,\"Hi\\\"x\"*");
    push_text("$DEF,0,4,\"a\\\\\"\"*");
    push_text("$DEF,6,9,\"\"*");
    push_text("$BLK,99999999999,4294967296*");
    push_text("$BLK,12ab,3x9*");
    push_text("$BLK,,*");
    push_text("$BLK,-1,5*");
    push_text("$MSG,3,2+,\"a\"*");
    push_text("$BLK,4x-,5*");
    push_text("$ABC,1,1*");
    push_text("$BLKS,1,1*");
    push_text("$BL,1,1*");
    push_text("$*");
    push_text("$BLK,5*");
    push_text("$MSG,1,2*");
    push_text("$MSG,1,2,\"abc*");
    push_text("$DEF,1,2,abc\"*");
    push_text("$BLK,1,2$MSG,5,1,\"ok\"*");
    // byte values 00, FF, 7F and 80 in text
    push_text("$MSG,0,0,\"");
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'h7F);
    frame_bytes.push_back(8'h80);
    push_text(",\\\"*");
    // text at capacity, then one over
    push_text("$DEF,1,1,\"");
    repeat (63) frame_bytes.push_back(text_byte());
    push_text("\"*");
    push_text("$DEF,1,1,\"");
    repeat (64) frame_bytes.push_back(text_byte());
    push_text("\"*");
    // frame of 127 bytes, then 128
    for (int k = 52; k <= 53; k++) begin
      push_text("$MSG,1,1,\"");
      repeat (63) frame_bytes.push_back(text_byte());
      frame_bytes.push_back(CH_QUOTE);
      repeat (k) frame_bytes.push_back(text_byte());
      frame_bytes.push_back(CH_STAR);
    end
    send_frames();
  endtask

  initial begin
    int start_bytes;
    int frames;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_frames();
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
          write_duration(32'hFFFF_FFFF);
        end
        1: begin
          sender_idle_pct = 55;
          recv_stall_pct  = 0;
          write_duration(32'd0);
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 55;
          write_duration($urandom);
        end
        default: begin
          sender_idle_pct = 20;
          recv_stall_pct  = 20;
          write_duration($urandom);
        end
      endcase
      start_bytes = bytes_sent;
      frames      = 0;
      while (bytes_sent - start_bytes < 30 || frames < 10) begin
        if ($urandom_range(4) != 0) build_good_frame();
        else build_broken_frame();
        send_frames();
        frames++;
      end
      drain();
    end
    if (mismatch_count == 0) begin
      $display("** display_command_parser: PASSED **");
    end else begin
      $display("** display_command_parser: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
